[hdl/mdr_pkg.sv]
package mdr_pkg;

    localparam int DUTY_BITS_DEF = 8;

    localparam int STEP_W     = 8;
    localparam int INTERVAL_W = 10;
    localparam int HOLD_W     = 16;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 1;

    localparam logic [STEP_W-1:0]     STEP_SIZE_RESET     = 8'd5;
    localparam logic [INTERVAL_W-1:0] STEP_INTERVAL_RESET = 10'd10;

    typedef enum logic [1:0] {
        PH_SETTLED = 2'd0,
        PH_RAMP    = 2'd1,
        PH_REVERSE = 2'd2,
        PH_HOLD    = 2'd3
    } phase_t;

    typedef enum logic [0:0] {
        OP_TICK = 1'b0,
        OP_CMD  = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_SIZE     = 1'b0,
        CFG_STEP_INTERVAL = 1'b1
    } cfg_idx_t;

    // ramp control state apart from the duty values
    typedef struct packed {
        logic                  dir_now;
        logic                  dir_goal;
        logic [INTERVAL_W-1:0] interval_count;
        logic [HOLD_W-1:0]     hold_count;
        logic                  hold_pending;
        phase_t                phase;
    } ctrl_t;

endpackage

[hdl/mdr_in_if.sv]
interface mdr_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic        direction;
    logic [7:0]  target_duty;
    logic        timed;
    logic [15:0] run_ms;

    modport source (output valid, op, direction, target_duty, timed, run_ms, input ready);
    modport sink   (input valid, op, direction, target_duty, timed, run_ms, output ready);
endinterface

[hdl/mdr_out_if.sv]
interface mdr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] duty_out;
    logic       dir_pin;
    logic [1:0] phase;

    modport source (output valid, duty_out, dir_pin, phase, input ready);
    modport sink   (input valid, duty_out, dir_pin, phase, output ready);
endinterface

[hdl/mdr_next.sv]
// Next ramp state for one word (tick or command).
module mdr_next #(
    parameter int DUTY_BITS = mdr_pkg::DUTY_BITS_DEF
) (
    input  mdr_pkg::ctrl_t                ctrl_cur,
    input  logic [DUTY_BITS-1:0]          duty_cur,
    input  logic [DUTY_BITS-1:0]          goal_cur,
    input  logic                          op,
    input  logic                          direction,
    input  logic [7:0]                    target_duty,
    input  logic                          timed,
    input  logic [15:0]                   run_ms,
    input  logic [mdr_pkg::STEP_W-1:0]    step_size,
    input  logic [mdr_pkg::INTERVAL_W-1:0] step_interval,
    output mdr_pkg::ctrl_t                ctrl_next,
    output logic [DUTY_BITS-1:0]          duty_next,
    output logic [DUTY_BITS-1:0]          goal_next
);

    localparam int EW = DUTY_BITS + 8;

    logic [mdr_pkg::STEP_W-1:0]     step_eff;
    logic [mdr_pkg::INTERVAL_W-1:0] iv_eff;
    logic [mdr_pkg::INTERVAL_W-1:0] count_inc;
    logic [EW-1:0]                  target_ext;
    logic [EW-1:0]                  step_ext;
    logic [DUTY_BITS-1:0]           diff;
    logic                           do_resolve;
    logic                           do_arrive;
    logic                           do_stop;

    assign step_eff   = (step_size == '0) ? mdr_pkg::STEP_W'(1) : step_size;
    assign iv_eff     = (step_interval == '0) ? mdr_pkg::INTERVAL_W'(1) : step_interval;
    assign count_inc  = ctrl_cur.interval_count + mdr_pkg::INTERVAL_W'(1);
    assign target_ext = {DUTY_BITS'(0), target_duty};
    assign step_ext   = EW'(step_eff);

    always_comb
    begin
        ctrl_next  = ctrl_cur;
        duty_next  = duty_cur;
        goal_next  = goal_cur;
        diff       = '0;
        do_resolve = 1'b0;
        do_arrive  = 1'b0;
        do_stop    = 1'b0;

        if (op == mdr_pkg::OP_CMD)
        begin
            ctrl_next.dir_goal       = direction;
            goal_next                = target_ext[DUTY_BITS-1:0];
            ctrl_next.hold_pending   = timed;
            ctrl_next.hold_count     = timed ? run_ms : '0;
            ctrl_next.interval_count = '0;
            if (direction != ctrl_cur.dir_now)
            begin
                if (duty_cur == '0)
                begin
                    ctrl_next.dir_now = direction;
                    do_resolve        = 1'b1;
                end
                else
                begin
                    ctrl_next.phase = mdr_pkg::PH_REVERSE;
                end
            end
            else
            begin
                do_resolve = 1'b1;
            end
        end
        else if (ctrl_cur.phase == mdr_pkg::PH_HOLD)
        begin
            if (ctrl_cur.hold_count != '0)
                ctrl_next.hold_count = ctrl_cur.hold_count - mdr_pkg::HOLD_W'(1);
            if (ctrl_next.hold_count == '0)
                do_stop = 1'b1;
        end
        else if (ctrl_cur.phase == mdr_pkg::PH_RAMP || ctrl_cur.phase == mdr_pkg::PH_REVERSE)
        begin
            if (count_inc >= iv_eff || count_inc == '0)
            begin
                ctrl_next.interval_count = '0;
                if (ctrl_cur.phase == mdr_pkg::PH_REVERSE)
                begin
                    if (EW'(duty_cur) <= step_ext)
                    begin
                        duty_next         = '0;
                        ctrl_next.dir_now = ctrl_cur.dir_goal;
                        do_resolve        = 1'b1;
                    end
                    else
                    begin
                        duty_next = DUTY_BITS'(EW'(duty_cur) - step_ext);
                    end
                end
                else
                begin
                    if (goal_cur > duty_cur)
                    begin
                        diff = goal_cur - duty_cur;
                        if (EW'(diff) <= step_ext)
                            duty_next = goal_cur;
                        else
                            duty_next = DUTY_BITS'(EW'(duty_cur) + step_ext);
                    end
                    else if (goal_cur < duty_cur)
                    begin
                        diff = duty_cur - goal_cur;
                        if (EW'(diff) <= step_ext)
                            duty_next = goal_cur;
                        else
                            duty_next = DUTY_BITS'(EW'(duty_cur) - step_ext);
                    end
                    if (duty_next == goal_cur)
                        do_arrive = 1'b1;
                end
            end
            else
            begin
                ctrl_next.interval_count = count_inc;
            end
        end

        if (do_resolve)
        begin
            if (duty_next != goal_next)
                ctrl_next.phase = mdr_pkg::PH_RAMP;
            else
                do_arrive = 1'b1;
        end

        if (do_arrive)
        begin
            ctrl_next.interval_count = '0;
            if (ctrl_next.hold_pending)
            begin
                if (ctrl_next.hold_count != '0)
                    ctrl_next.phase = mdr_pkg::PH_HOLD;
                else
                    do_stop = 1'b1;
            end
            else
            begin
                ctrl_next.phase = mdr_pkg::PH_SETTLED;
            end
        end

        // stop ramp: goal to zero, settle at once if already there
        if (do_stop)
        begin
            ctrl_next.hold_pending   = 1'b0;
            goal_next                = '0;
            ctrl_next.interval_count = '0;
            ctrl_next.phase          = (duty_next != '0) ? mdr_pkg::PH_RAMP
                                                         : mdr_pkg::PH_SETTLED;
        end
    end

endmodule

[hdl/motor_duty_ramp_with_reversal_unit.sv]
// Channel   Dir  Modport   Payload
// in_ch     in   sink      op, direction, target_duty[7:0], timed, run_ms[15:0]
// out_ch    out  source    duty_out[7:0], dir_pin, phase[1:0]
// cfg       in   write     cfg_we, cfg_index[0:0], cfg_wdata[9:0]
//
// One result word per input word, registered and valid on the cycle after acceptance.
// A new word can be taken every cycle while no result is stalled; the state update
// is one pass of compare/add logic in mdr_next between the state and result registers.
// in_ch.ready drops only while a result is held and out_ch is stalled.
// Reset (rst_n low, async) clears the ramp state, empties the result register
// and loads step_size = 5, step_interval_ms = 10.
module motor_duty_ramp_with_reversal_unit #(
    parameter int DUTY_BITS = mdr_pkg::DUTY_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    mdr_in_if.sink                           in_ch,
    mdr_out_if.source                        out_ch,
    input  logic                             cfg_we,
    input  logic [mdr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mdr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    // configuration registers
    logic [mdr_pkg::STEP_W-1:0]     step_size_reg;
    logic [mdr_pkg::INTERVAL_W-1:0] step_interval_reg;

    // ramp state
    mdr_pkg::ctrl_t        ctrl_reg;
    mdr_pkg::ctrl_t        ctrl_next;
    logic [DUTY_BITS-1:0]  duty_reg;
    logic [DUTY_BITS-1:0]  duty_next;
    logic [DUTY_BITS-1:0]  goal_reg;
    logic [DUTY_BITS-1:0]  goal_next;

    // result register
    logic                  out_valid_reg;
    logic [7:0]            duty_out_reg;
    logic                  dir_pin_reg;
    logic [1:0]            phase_reg;

    logic                  in_fire;
    logic [DUTY_BITS+7:0]  duty_wide;

    // result slot frees up when the downstream takes it this cycle
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;

    // driven duty is the low byte of the ramp value
    assign duty_wide = {8'b0, duty_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg     <= mdr_pkg::STEP_SIZE_RESET;
            step_interval_reg <= mdr_pkg::STEP_INTERVAL_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == mdr_pkg::CFG_STEP_SIZE)
                step_size_reg <= cfg_wdata[mdr_pkg::STEP_W-1:0];
            else if (cfg_index == mdr_pkg::CFG_STEP_INTERVAL)
                step_interval_reg <= cfg_wdata[mdr_pkg::INTERVAL_W-1:0];
        end
    end

    mdr_next #(
        .DUTY_BITS (DUTY_BITS)
    ) u_next (
        .ctrl_cur      (ctrl_reg),
        .duty_cur      (duty_reg),
        .goal_cur      (goal_reg),
        .op            (in_ch.op),
        .direction     (in_ch.direction),
        .target_duty   (in_ch.target_duty),
        .timed         (in_ch.timed),
        .run_ms        (in_ch.run_ms),
        .step_size     (step_size_reg),
        .step_interval (step_interval_reg),
        .ctrl_next     (ctrl_next),
        .duty_next     (duty_next),
        .goal_next     (goal_next)
    );

    // state commits only on an accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '{dir_now: 1'b0, dir_goal: 1'b0, interval_count: '0,
                          hold_count: '0, hold_pending: 1'b0,
                          phase: mdr_pkg::PH_SETTLED};
            duty_reg <= '0;
            goal_reg <= '0;
        end
        else if (in_fire)
        begin
            ctrl_reg <= ctrl_next;
            duty_reg <= duty_next;
            goal_reg <= goal_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            duty_out_reg <= duty_wide[7:0];
            dir_pin_reg  <= ctrl_next.dir_now;
            phase_reg    <= ctrl_next.phase;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.duty_out = duty_out_reg;
    assign out_ch.dir_pin  = dir_pin_reg;
    assign out_ch.phase    = phase_reg;

    // hold is only ever entered with a pending timed run
    a_hold_pending: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_reg.phase == mdr_pkg::PH_HOLD |-> ctrl_reg.hold_pending)
        else $error("hold phase without pending timed run");

    // holding means the goal was reached
    a_hold_at_goal: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_reg.phase == mdr_pkg::PH_HOLD |-> duty_reg == goal_reg)
        else $error("hold phase away from goal duty");

    // interval counter idles at zero when settled
    a_settled_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_reg.phase == mdr_pkg::PH_SETTLED |-> ctrl_reg.interval_count == '0)
        else $error("interval count running while settled");

    // every accepted word yields a result next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted word produced no result");

endmodule

[test/ramp_check_pkg.sv]
package ramp_check_pkg;

    typedef struct packed {
        mdr_pkg::op_t op;
        logic         direction;
        logic [7:0]   target_duty;
        logic         timed;
        logic [15:0]  run_ms;
    } cmd_word_t;

    typedef struct packed {
        logic [7:0] duty_out;
        logic       dir_pin;
        logic [1:0] phase;
    } duty_word_t;

    // Tracks the ramp state and queues the duty word each input word should produce.
    class duty_ramp_scoreboard;

        logic [mdr_pkg::STEP_W-1:0]     step_size;
        logic [mdr_pkg::INTERVAL_W-1:0] step_interval;

        logic [7:0]                     duty_now;
        logic [7:0]                     duty_goal;
        logic                           dir_now;
        logic                           dir_goal;
        logic [mdr_pkg::INTERVAL_W-1:0] interval_count;
        logic [mdr_pkg::HOLD_W-1:0]     hold_count;
        logic                           hold_pending;
        mdr_pkg::phase_t                phase_now;

        duty_word_t                     expected_duty_q[$];
        int unsigned                    errors;

        function new();
            step_size      = mdr_pkg::STEP_SIZE_RESET;
            step_interval  = mdr_pkg::STEP_INTERVAL_RESET;
            duty_now       = '0;
            duty_goal      = '0;
            dir_now        = 1'b0;
            dir_goal       = 1'b0;
            interval_count = '0;
            hold_count     = '0;
            hold_pending   = 1'b0;
            phase_now      = mdr_pkg::PH_SETTLED;
            errors         = 0;
        endfunction

        function void write_reg(mdr_pkg::cfg_idx_t idx, logic [mdr_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                mdr_pkg::CFG_STEP_SIZE:     step_size     = data[mdr_pkg::STEP_W-1:0];
                mdr_pkg::CFG_STEP_INTERVAL: step_interval = data[mdr_pkg::INTERVAL_W-1:0];
                default:                    ;
            endcase
        endfunction

        function int pending();
            return expected_duty_q.size();
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("%s", msg);
        endfunction

        function void start_stop_ramp();
            hold_pending   = 1'b0;
            duty_goal      = '0;
            interval_count = '0;
            phase_now      = (duty_now != 0) ? mdr_pkg::PH_RAMP : mdr_pkg::PH_SETTLED;
        endfunction

        function void reach_goal();
            interval_count = '0;
            if (hold_pending)
            begin
                if (hold_count != 0)
                    phase_now = mdr_pkg::PH_HOLD;
                else
                    start_stop_ramp();
            end
            else
            begin
                phase_now = mdr_pkg::PH_SETTLED;
            end
        endfunction

        function void head_for_goal();
            if (duty_now != duty_goal)
                phase_now = mdr_pkg::PH_RAMP;
            else
                reach_goal();
        endfunction

        function void note_word(cmd_word_t w);
            int unsigned step;
            int unsigned period;
            int unsigned count;
            int unsigned now_i;
            int unsigned goal_i;
            if (w.op == mdr_pkg::OP_CMD)
            begin
                dir_goal       = w.direction;
                duty_goal      = w.target_duty;
                hold_pending   = w.timed;
                hold_count     = w.timed ? w.run_ms : '0;
                interval_count = '0;
                if (dir_goal != dir_now)
                begin
                    // pin flips right away when already stopped
                    if (duty_now == 0)
                    begin
                        dir_now = dir_goal;
                        head_for_goal();
                    end
                    else
                    begin
                        phase_now = mdr_pkg::PH_REVERSE;
                    end
                end
                else
                begin
                    head_for_goal();
                end
            end
            else if (phase_now == mdr_pkg::PH_HOLD)
            begin
                if (hold_count != 0)
                    hold_count--;
                if (hold_count == 0)
                    start_stop_ramp();
            end
            else if (phase_now == mdr_pkg::PH_RAMP || phase_now == mdr_pkg::PH_REVERSE)
            begin
                period = (step_interval == 0) ? 1 : step_interval;
                count  = (interval_count + 1) % 1024;
                if (count >= period || count == 0)
                begin
                    interval_count = '0;
                    step   = (step_size == 0) ? 1 : step_size;
                    now_i  = duty_now;
                    goal_i = duty_goal;
                    if (phase_now == mdr_pkg::PH_REVERSE)
                    begin
                        if (now_i <= step)
                        begin
                            duty_now = '0;
                            dir_now  = dir_goal;
                            head_for_goal();
                        end
                        else
                        begin
                            duty_now = 8'(now_i - step);
                        end
                    end
                    else
                    begin
                        // last partial step lands exactly on the goal
                        if (goal_i > now_i)
                            duty_now = (goal_i - now_i <= step) ? duty_goal : 8'(now_i + step);
                        else if (goal_i < now_i)
                            duty_now = (now_i - goal_i <= step) ? duty_goal : 8'(now_i - step);
                        if (duty_now == duty_goal)
                            reach_goal();
                    end
                end
                else
                begin
                    interval_count = count[mdr_pkg::INTERVAL_W-1:0];
                end
            end
            expected_duty_q.push_back('{duty_now, dir_now, phase_now});
        endfunction

        function void check_word(duty_word_t got);
            duty_word_t want;
            string      exp_s;
            string      got_s;
            if (expected_duty_q.size() == 0)
            begin
                flag($sformatf("unexpected duty word: duty=%0d dir=%0d phase=%0d",
                               got.duty_out, got.dir_pin, got.phase));
                return;
            end
            want = expected_duty_q.pop_front();
            if (got.duty_out !== want.duty_out || got.dir_pin !== want.dir_pin ||
                got.phase !== want.phase)
            begin
                exp_s = $sformatf("duty=%0d dir=%0d phase=%0d",
                                  want.duty_out, want.dir_pin, want.phase);
                got_s = $sformatf("duty=%0d dir=%0d phase=%0d",
                                  got.duty_out, got.dir_pin, got.phase);
                flag({"duty word mismatch: exp ", exp_s, ", got ", got_s});
            end
        endfunction

    endclass

endpackage

[test/tb_motor_duty_ramp_with_reversal_unit.sv]
module tb_motor_duty_ramp_with_reversal_unit;

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles with no word moving on either side before the run is declared hung.
    localparam int STALL_LIMIT  = 4000;
    // Spare idle cycles waited after the last expected word has been checked.
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 140;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    // Register settings per random phase: extremes, zero (acts as one), and
    // an interval drop after a long interval to catch a count above the new limit.
    int unsigned step_plan     [PHASES] = '{5, 255, 1, 37, 0, 64, 20, 8};
    int unsigned interval_plan [PHASES] = '{10, 1, 1, 3, 0, 1000, 2, 5};

    logic clk = 1'b0;
    logic rst_n;
    logic                           cfg_we;
    logic [mdr_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [mdr_pkg::CFG_DATA_W-1:0] cfg_wdata;

    mdr_in_if  in_ch ();
    mdr_out_if out_ch ();

    ramp_check_pkg::duty_ramp_scoreboard sb;
    idle_mode_t          mode = IDLE_NONE;
    int unsigned         quiet_cycles = 0;

    motor_duty_ramp_with_reversal_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Every accepted input word feeds the predictor.
    always @(posedge clk)
    begin
        if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
            sb.note_word('{mdr_pkg::op_t'(in_ch.op), in_ch.direction, in_ch.target_duty,
                           in_ch.timed, in_ch.run_ms});
    end

    // Receiver: check each accepted duty word, then pick the next ready level.
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
                sb.check_word({out_ch.duty_out, out_ch.dir_pin, out_ch.phase});
            case (mode)
                IDLE_RECV: out_ch.ready <= ($urandom_range(0, 99) >= 64);
                IDLE_BOTH: out_ch.ready <= ($urandom_range(0, 99) >= 16);
                default:   out_ch.ready <= 1'b1;
            endcase
        end
    end

    // Watchdog: ends a run in which nothing moves for too long.
    always @(posedge clk)
    begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[motor_duty_ramp_with_reversal_unit] ERROR");
            $finish;
        end
    end

    // Random word: mostly ticks so ramps and holds run their course, with
    // commands often enough to cut into ramps, holds and reversals.
    function automatic ramp_check_pkg::cmd_word_t random_word();
        ramp_check_pkg::cmd_word_t w;
        w.op        = ($urandom_range(0, 5) == 0) ? mdr_pkg::OP_CMD : mdr_pkg::OP_TICK;
        w.direction = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0:       w.target_duty = 8'd0;
            1:       w.target_duty = 8'd255;
            default: w.target_duty = 8'($urandom_range(0, 255));
        endcase
        w.timed  = 1'($urandom_range(0, 1));
        // short holds so they finish; the odd full-range one gets overridden
        w.run_ms = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
        return w;
    endfunction

    // Offer one word; returns right after the edge that accepted it.
    task automatic push_word(input ramp_check_pkg::cmd_word_t w);
        int unsigned gap_pct;
        gap_pct = (mode == IDLE_SEND) ? 64 : (mode == IDLE_BOTH) ? 16 : 0;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.op          <= w.op;
        in_ch.direction   <= w.direction;
        in_ch.target_duty <= w.target_duty;
        in_ch.timed       <= w.timed;
        in_ch.run_ms      <= w.run_ms;
        @(posedge clk);
        while (in_ch.ready !== 1'b1)
            @(posedge clk);
    endtask

    task automatic send_cmd(input logic dir, input int unsigned duty,
                            input logic timed, input int unsigned run);
        push_word('{mdr_pkg::OP_CMD, dir, 8'(duty), timed, 16'(run)});
    endtask

    // Tick with random don't-care payload bits.
    task automatic send_ticks(input int unsigned n);
        ramp_check_pkg::cmd_word_t w;
        repeat (n)
        begin
            w    = random_word();
            w.op = mdr_pkg::OP_TICK;
            push_word(w);
        end
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input mdr_pkg::cfg_idx_t idx, input int unsigned value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= mdr_pkg::CFG_DATA_W'(value);
        sb.write_reg(idx, mdr_pkg::CFG_DATA_W'(value));
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Registers only change with nothing in flight; ramp state carries over.
    task automatic configure(input int unsigned step, input int unsigned interval);
        wait_drained();
        write_reg(mdr_pkg::CFG_STEP_SIZE, step);
        write_reg(mdr_pkg::CFG_STEP_INTERVAL, interval);
    endtask

    initial
    begin
        sb = new();
        rst_n             <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.op          <= mdr_pkg::OP_TICK;
        in_ch.direction   <= 1'b0;
        in_ch.target_duty <= '0;
        in_ch.timed       <= 1'b0;
        in_ch.run_ms      <= '0;
        cfg_we            <= 1'b0;
        cfg_index         <= mdr_pkg::CFG_STEP_SIZE;
        cfg_wdata         <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: big steps, short interval so each case plays out fast.
        configure(100, 2);
        send_cmd(1'b0, 0, 1'b0, 0);        // goal already met: settles on the command
        send_cmd(1'b1, 0, 1'b0, 0);        // reversal at zero duty: pin flips at once
        send_cmd(1'b1, 255, 1'b1, 2);      // timed run to full duty
        send_ticks(6);                     // 100, 200, then partial step lands on 255
        send_ticks(2);                     // hold runs out, stop ramp starts
        send_ticks(1);
        send_cmd(1'b0, 255, 1'b1, 65535);  // reversal from high duty: ramp down first
        send_ticks(4);
        send_cmd(1'b1, 40, 1'b1, 0);       // new command mid-reversal, zero-length hold
        send_ticks(4);                     // lands on 40, stop begins at once, down to 0
        send_cmd(1'b0, 0, 1'b1, 3);        // timed goal of zero: hold at zero duty
        send_ticks(3);
        send_cmd(1'b0, 0, 1'b1, 0);        // zero-length hold with goal met

        // Random part: one register setting and one idle pattern per phase.
        for (int p = 0; p < PHASES; p++)
        begin
            configure(step_plan[p], interval_plan[p]);
            mode = idle_mode_t'(p % 4);
            repeat (PHASE_WORDS) push_word(random_word());
        end

        wait_drained();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[motor_duty_ramp_with_reversal_unit] OK");
        else
            $display("[motor_duty_ramp_with_reversal_unit] ERROR");
        $finish;
    end

endmodule

[filelist.f]
hdl/mdr_pkg.sv
hdl/mdr_in_if.sv
hdl/mdr_out_if.sv
hdl/mdr_next.sv
hdl/motor_duty_ramp_with_reversal_unit.sv
test/ramp_check_pkg.sv
test/tb_motor_duty_ramp_with_reversal_unit.sv
